// File: src/tsc_pkg.sv
// Shared constants, types and microcode for the Taylor sine/cosine block.
// Depends on nothing; imported by taylor_sine_cosine.
package tsc_pkg;

  localparam int FRAC_BITS = 29;
  localparam int MAX_TERMS = 32;

  localparam int ANGLE_W = 32;
  localparam int THR_W   = 30;
  localparam int CNT_W   = 6;
  localparam int MAG_W   = 57;              // term magnitude, capped at 2^56
  localparam int X2_W    = 34;              // x*x >> FRAC_BITS
  localparam int SUM_W   = 64;
  localparam int MULA_W  = 32;
  localparam int MULB_W  = 17;
  localparam int PP_W    = MULA_W + MULB_W;
  localparam int ACC_W   = 91;              // holds mag * x2 exactly
  localparam int SHR_W   = ACC_W - FRAC_BITS;
  localparam int DQ_W    = 64;              // dividend / quotient shift register
  localparam int DEN_W   = 13;              // largest factor product is 64*65
  localparam int DIV_BITS = 8;              // quotient bits resolved per cycle
  localparam int DIV_CYC  = DQ_W / DIV_BITS;
  localparam int DCNT_W   = $clog2(DIV_CYC);
  localparam int PC_W     = 4;

  localparam logic [MAG_W-1:0] TERM_CAP = MAG_W'(1) << (MAG_W - 1);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(537);

  typedef enum logic [3:0] {
    OP_SQ_LO = 4'd0,
    OP_SQ_HI = 4'd1,
    OP_LDX2  = 4'd2,
    OP_M00   = 4'd3,
    OP_M01   = 4'd4,
    OP_M10   = 4'd5,
    OP_M11   = 4'd6,
    OP_SAT   = 4'd7,
    OP_DIV   = 4'd8,
    OP_ACC   = 4'd9,
    OP_DEN   = 4'd10,
    OP_EMIT  = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    C_NEXT = 2'd0,   // fall through
    C_DIV  = 2'd1,   // loop to target until the divider is done
    C_MORE = 2'd2,   // jump to target unless the series stops
    C_END  = 2'd3    // leave the program
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_TERM = PC_W'(3);
  localparam logic [PC_W-1:0] PC_DIV  = PC_W'(8);
  localparam logic [PC_W-1:0] PC_NONE = PC_W'(0);

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_W'(0):  w = '{OP_SQ_LO, C_NEXT, PC_NONE};
      PC_W'(1):  w = '{OP_SQ_HI, C_NEXT, PC_NONE};
      PC_W'(2):  w = '{OP_LDX2,  C_NEXT, PC_NONE};
      PC_W'(3):  w = '{OP_M00,   C_NEXT, PC_NONE};
      PC_W'(4):  w = '{OP_M01,   C_NEXT, PC_NONE};
      PC_W'(5):  w = '{OP_M10,   C_NEXT, PC_NONE};
      PC_W'(6):  w = '{OP_M11,   C_NEXT, PC_NONE};
      PC_W'(7):  w = '{OP_SAT,   C_NEXT, PC_NONE};
      PC_W'(8):  w = '{OP_DIV,   C_DIV,  PC_DIV};
      PC_W'(9):  w = '{OP_ACC,   C_NEXT, PC_NONE};
      PC_W'(10): w = '{OP_DEN,   C_MORE, PC_TERM};
      PC_W'(11): w = '{OP_EMIT,  C_END,  PC_NONE};
      default:   w = '{OP_EMIT,  C_END,  PC_NONE};
    endcase
    return w;
  endfunction

  // Factor product for term k: (2k-1)(2k) for cosine, (2k)(2k+1) for sine
  function automatic logic [DEN_W-1:0] den_f(input logic [CNT_W:0] k, input logic cosine);
    logic [CNT_W+1:0] two_k;
    logic [CNT_W+1:0] other;
    logic [2*CNT_W+3:0] prod;
    two_k = {k, 1'b0};
    other = cosine ? two_k - (CNT_W+2)'(1) : two_k + (CNT_W+2)'(1);
    prod  = (2*CNT_W+4)'(two_k) * (2*CNT_W+4)'(other);
    return prod[DEN_W-1:0];
  endfunction

endpackage

// File: src/taylor_sine_cosine.sv
// Taylor-series sine/cosine: microcoded sequencer, shared 32x17 multiplier,
// 8-bit-per-cycle restoring divider. Depends on tsc_pkg.
//
// Usage:
//   Pulse start with func (0 sine, 1 cosine) and angle (signed Q2.29) while
//   busy is low; the transaction is taken at that edge and busy rises.
//   When the series finishes, done is high for exactly one cycle with value
//   (sum saturated to signed Q2.29), terms_used and limit_hit; busy drops in
//   that same cycle, so the next start may be taken while done is shown.
//   The receiver cannot stall; done is not held beyond that cycle, but value,
//   terms_used and limit_hit keep their contents until the next result.
//   The series adds 1 to 32 terms. After accept, 3 setup steps form x*x,
//   then each term takes 4 multiply steps, 1 saturation step, 8 divide
//   steps and 2 update steps. No new start is taken while busy; the next
//   start is taken at the edge that ends the done cycle.
//   stop_threshold is written through cfg_valid/cfg_ready/cfg_data while
//   busy and start are both low. Synchronous reset clears busy and done and
//   loads the threshold with 537.
module taylor_sine_cosine import tsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      func,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic        [THR_W-1:0]   cfg_data,
  output logic                      done,
  output logic signed [ANGLE_W-1:0] value,
  output logic        [CNT_W-1:0]   terms_used,
  output logic                      limit_hit
);

  logic [THR_W-1:0]         thr;
  logic [PC_W-1:0]          pc;
  logic [DCNT_W-1:0]        div_cnt;
  logic                     cosine;
  logic                     neg;
  logic [ANGLE_W-1:0]       xmag;
  logic [X2_W-1:0]          x2;
  logic [MAG_W-1:0]         mag;
  logic signed [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]         count;
  logic [ACC_W-1:0]         acc;
  logic [DQ_W-1:0]          dq;
  logic [DEN_W-1:0]         rem;
  logic [DEN_W-1:0]         denom;

  uword_t                   uw;
  logic [MULA_W-1:0]        mul_a;
  logic [MULB_W-1:0]        mul_b;
  logic [PP_W-1:0]          pp;
  logic [ACC_W-1:0]         acc_next;
  logic [SHR_W-1:0]         shr;
  logic [MAG_W-1:0]         mag_sat;
  logic [DQ_W-1:0]          dq_next;
  logic [DEN_W-1:0]         rem_next;
  logic                     stop;
  logic [ANGLE_W-1:0]       angle_mag;
  logic signed [ANGLE_W-1:0] value_next;
  logic signed [SUM_W-1:0]  term_ext;

  assign uw        = ucode(pc);
  // Hold off threshold writes while busy or while a command is being taken
  assign cfg_ready = !busy && !start;
  assign angle_mag = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
  assign stop      = (mag < MAG_W'(thr)) || (count >= CNT_W'(MAX_TERMS));
  assign term_ext  = signed'(SUM_W'(dq[MAG_W-1:0]));

  // Shared multiplier and accumulator
  always_comb begin
    mul_a    = xmag;
    mul_b    = xmag[MULB_W-1:0];
    acc_next = acc;
    unique case (uw.op)
      OP_SQ_LO: begin
        mul_a = xmag;
        mul_b = xmag[MULB_W-1:0];
      end
      OP_SQ_HI: begin
        mul_a = xmag;
        mul_b = MULB_W'(xmag[ANGLE_W-1:MULB_W]);
      end
      OP_M00: begin
        mul_a = mag[MULA_W-1:0];
        mul_b = x2[MULB_W-1:0];
      end
      OP_M01: begin
        mul_a = mag[MULA_W-1:0];
        mul_b = x2[X2_W-1:MULB_W];
      end
      OP_M10: begin
        mul_a = MULA_W'(mag[MAG_W-1:MULA_W]);
        mul_b = x2[MULB_W-1:0];
      end
      OP_M11: begin
        mul_a = MULA_W'(mag[MAG_W-1:MULA_W]);
        mul_b = x2[X2_W-1:MULB_W];
      end
      default: begin
        mul_a = xmag;
        mul_b = xmag[MULB_W-1:0];
      end
    endcase
    pp = PP_W'(mul_a) * PP_W'(mul_b);
    unique case (uw.op)
      OP_SQ_LO, OP_M00: acc_next = ACC_W'(pp);
      OP_SQ_HI, OP_M01: acc_next = acc + (ACC_W'(pp) << MULB_W);
      OP_M10:           acc_next = acc + (ACC_W'(pp) << MULA_W);
      OP_M11:           acc_next = acc + (ACC_W'(pp) << PP_W);
      default:          acc_next = acc;
    endcase
  end

  // Cap the shifted product at 2^56
  assign shr     = acc[ACC_W-1:FRAC_BITS];
  assign mag_sat = (shr > SHR_W'(TERM_CAP)) ? TERM_CAP : shr[MAG_W-1:0];

  // Restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [DEN_W:0] trial;
    dq_next  = dq;
    rem_next = rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_next, dq_next[DQ_W-1]};
      if (trial >= (DEN_W+1)'(denom)) begin
        rem_next = DEN_W'(trial - (DEN_W+1)'(denom));
        dq_next  = {dq_next[DQ_W-2:0], 1'b1};
      end else begin
        rem_next = trial[DEN_W-1:0];
        dq_next  = {dq_next[DQ_W-2:0], 1'b0};
      end
    end
  end

  // Saturate the 64-bit sum to the output width
  always_comb begin
    if (sum[SUM_W-1:ANGLE_W-1] == '0 || sum[SUM_W-1:ANGLE_W-1] == '1) begin
      value_next = sum[ANGLE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      value_next = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      value_next = {1'b0, {(ANGLE_W-1){1'b1}}};
    end
  end

  // Sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pc   <= '0;
      thr  <= THR_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          pc   <= '0;
        end
      end else begin
        unique case (uw.cond)
          C_NEXT: pc <= pc + PC_W'(1);
          C_DIV:  pc <= (div_cnt == DCNT_W'(DIV_CYC - 1)) ? pc + PC_W'(1) : uw.target;
          C_MORE: pc <= stop ? pc + PC_W'(1) : uw.target;
          C_END: begin
            busy <= 1'b0;
            done <= 1'b1;
            pc   <= '0;
          end
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (!busy) begin
      if (start) begin
        cosine <= func;
        xmag   <= angle_mag;
        count  <= '0;
        if (func) begin
          mag <= MAG_W'(1) << FRAC_BITS;
          neg <= 1'b0;
          sum <= SUM_W'(1) << FRAC_BITS;
        end else begin
          mag <= MAG_W'(angle_mag);
          neg <= angle[ANGLE_W-1];
          sum <= SUM_W'(angle);
        end
      end
    end else begin
      unique case (uw.op)
        OP_SQ_LO, OP_SQ_HI, OP_M00, OP_M01, OP_M10, OP_M11: acc <= acc_next;
        OP_LDX2: begin
          x2    <= acc[FRAC_BITS +: X2_W];
          denom <= den_f((CNT_W+1)'(count) + (CNT_W+1)'(1), cosine);
        end
        OP_SAT: begin
          dq      <= DQ_W'(mag_sat);
          rem     <= '0;
          div_cnt <= '0;
        end
        OP_DIV: begin
          dq      <= dq_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + DCNT_W'(1);
        end
        OP_ACC: begin
          mag   <= dq[MAG_W-1:0];
          neg   <= !neg;
          sum   <= neg ? sum + term_ext : sum - term_ext;
          count <= count + CNT_W'(1);
        end
        OP_DEN: denom <= den_f((CNT_W+1)'(count) + (CNT_W+1)'(1), cosine);
        OP_EMIT: begin
          value      <= value_next;
          terms_used <= count;
          limit_hit  <= (mag >= MAG_W'(thr));
        end
        default: ;
      endcase
    end
  end

  // A result only appears as the program leaves
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result strobe");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_term_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (count != '0) && (count <= CNT_W'(MAX_TERMS)))
    else $error("term count out of range");

  a_limit_at_cap: assert property (@(posedge clk) disable iff (rst)
    (done && limit_hit) |-> (count == CNT_W'(MAX_TERMS)))
    else $error("limit flag set before the term cap");

  a_mag_capped: assert property (@(posedge clk) disable iff (rst)
    (busy && pc == PC_DIV) |-> (mag <= TERM_CAP))
    else $error("term magnitude above cap");

endmodule
